// File: src/pit3_pkg.sv
// Shared types and constants for the three-channel interval timer.
// Depends on nothing; every other source file imports this package.
`default_nettype none

package pit3_pkg;

    // Item kinds on the input stream.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Port 3 is the control word register.
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // Access modes from the control word.
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_MSB   = 2'd2;
    localparam logic [1:0] ACC_WORD  = 2'd3;

    // Counting modes.
    localparam logic [2:0] MODE_RATE   = 3'd2;
    localparam logic [2:0] MODE_SQUARE = 3'd3;
    localparam logic [2:0] MODE_LAST   = 3'd5;
    localparam logic [2:0] MODE_FOLD   = 3'd4;

    // A reload byte pattern of zero means a full 65536-tick period.
    localparam logic [16:0] FULL_COUNT = 17'h10000;

    localparam int NUM_SLOTS    = 3;
    localparam int CHANNELS_DEF = 3;

    // Per-channel command decoded from one item.
    typedef struct packed {
        logic       tick;
        logic       rd;
        logic       wr;
        logic       ctrl;
        logic [7:0] data;
    } pit3_cmd_t;

    // Per-channel response for the result register.
    typedef struct packed {
        logic [7:0] rdata;
        logic       out_line;
    } pit3_rsp_t;

endpackage

`default_nettype wire

// File: src/pit3_channel.sv
// One timer channel: count state, latch, byte toggles and OUT line.
// Depends on pit3_pkg for the command and response structs and codes.
`default_nettype none

module pit3_channel
    import pit3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire pit3_cmd_t cmd,
    output pit3_rsp_t  rsp
);

    logic [16:0] reload_reg, reload_next;
    logic [15:0] phase_reg, phase_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  access_reg, access_next;
    logic        rhi_reg, rhi_next;
    logic        whi_reg, whi_next;
    logic        latch_reg, latch_next;
    logic [16:0] latched_reg, latched_next;
    logic [15:0] hold_reg, hold_next;

    logic [16:0] count;
    logic [16:0] rd_count;
    logic [16:0] phase_inc;
    logic [2:0]  new_mode;
    logic        do_reload;

    // Live count from the current state.
    always_comb begin
        if (reload_reg == 17'd0) begin
            count = 17'd0;
        end else if (mode_reg == MODE_RATE || mode_reg == MODE_SQUARE) begin
            count = reload_reg - {1'b0, phase_reg};
        end else if (elapsed_reg >= reload_reg) begin
            count = 17'd0;
        end else begin
            count = reload_reg - elapsed_reg;
        end
    end

    assign rd_count  = latch_reg ? latched_reg : count;
    assign phase_inc = {1'b0, phase_reg} + 17'd1;
    assign new_mode  = (cmd.data[3:1] > MODE_LAST) ? cmd.data[3:1] - MODE_FOLD
                                                   : cmd.data[3:1];

    always_comb begin
        reload_next  = reload_reg;
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        mode_next    = mode_reg;
        access_next  = access_reg;
        rhi_next     = rhi_reg;
        whi_next     = whi_reg;
        latch_next   = latch_reg;
        latched_next = latched_reg;
        hold_next    = hold_reg;
        rsp.rdata    = 8'hff;
        do_reload    = 1'b0;

        if (cmd.tick) begin
            if (reload_reg != 17'd0) begin
                phase_next = (phase_inc >= reload_reg) ? 16'd0 : phase_inc[15:0];
                if (elapsed_reg < reload_reg) begin
                    elapsed_next = elapsed_reg + 17'd1;
                end
            end
        end

        if (cmd.rd) begin
            if (access_reg == ACC_MSB) begin
                rsp.rdata  = rd_count[15:8];
                latch_next = 1'b0;
            end else if (access_reg == ACC_WORD) begin
                rsp.rdata = rhi_reg ? rd_count[15:8] : rd_count[7:0];
                rhi_next  = ~rhi_reg;
                // The latch is only released once the high byte is taken.
                if (rhi_reg) begin
                    latch_next = 1'b0;
                end
            end else begin
                rsp.rdata  = rd_count[7:0];
                latch_next = 1'b0;
            end
        end

        if (cmd.ctrl) begin
            if (cmd.data[5:4] == ACC_LATCH) begin
                if (!latch_reg) begin
                    latched_next = count;
                    latch_next   = 1'b1;
                end
            end else begin
                access_next = cmd.data[5:4];
                mode_next   = new_mode;
                whi_next    = 1'b0;
                rhi_next    = 1'b0;
                latch_next  = 1'b0;
            end
        end

        if (cmd.wr) begin
            if (access_reg == ACC_WORD) begin
                if (!whi_reg) begin
                    hold_next = {8'h00, cmd.data};
                    whi_next  = 1'b1;
                end else begin
                    hold_next = {cmd.data, hold_reg[7:0]};
                    whi_next  = 1'b0;
                    do_reload = 1'b1;
                end
            end else if (access_reg == ACC_MSB) begin
                hold_next = {cmd.data, 8'h00};
                do_reload = 1'b1;
            end else begin
                hold_next = {8'h00, cmd.data};
                do_reload = 1'b1;
            end
            if (do_reload) begin
                reload_next  = (hold_next == 16'd0) ? FULL_COUNT : {1'b0, hold_next};
                phase_next   = 16'd0;
                elapsed_next = 17'd0;
            end
        end
    end

    // OUT line as it stands after this item.
    always_comb begin
        if (reload_next == 17'd0) begin
            rsp.out_line = 1'b0;
        end else if (mode_next == MODE_SQUARE) begin
            rsp.out_line = {1'b0, phase_next} < ((reload_next + 17'd1) >> 1);
        end else if (mode_next == MODE_RATE) begin
            rsp.out_line = {1'b0, phase_next} != (reload_next - 17'd1);
        end else begin
            rsp.out_line = elapsed_next >= reload_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg  <= '0;
            phase_reg   <= '0;
            elapsed_reg <= '0;
            mode_reg    <= '0;
            access_reg  <= '0;
            rhi_reg     <= 1'b0;
            whi_reg     <= 1'b0;
            latch_reg   <= 1'b0;
            latched_reg <= '0;
            hold_reg    <= '0;
        end else begin
            reload_reg  <= reload_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            mode_reg    <= mode_next;
            access_reg  <= access_next;
            rhi_reg     <= rhi_next;
            whi_reg     <= whi_next;
            latch_reg   <= latch_next;
            latched_reg <= latched_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

`default_nettype wire

// File: src/interval_timer_three_channel_unit.sv
// Top level of the three-channel interval timer: stream ports, input and
// result registers, command decode. Depends on pit3_pkg and pit3_channel.
`default_nettype none

// Usage:
// Each item on the slave stream is one timer clock tick, one bus read or one
// bus write on ports 0 to 3; port 3 takes control words. For every item
// exactly one result item leaves on the master stream, carrying the read
// byte (255 unless a counter channel was read) and the three OUT lines as
// they stand after the item.
// An accepted item lands in an input register; once the result register
// is free, the channel logic updates its state and the result is captured
// in the result register, which drives m_tvalid. One item is taken every
// cycle while the receiver keeps up.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one, so s_tready drops only once both are
// full; nothing is lost or repeated. The one-cycle rate is set by the
// per-channel update, a single increment and compare per tick.
// Synchronous reset (aresetn low) empties both registers and returns every
// channel to the unprogrammed state: count 0, OUT low, access mode LSB.
// Channels at or above CHANNELS are absent: they read 255 and drive OUT 0.
module interval_timer_three_channel_unit
    import pit3_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] kind, [3:2] port, [11:4] data, [15:12] zero
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_data, [8] out_zero, [9] out_one, [10] out_two, [15:11] zero
    output logic [15:0]      m_tdata
);

    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [1:0] in_port_reg;
    logic [7:0] in_data_reg;

    logic       out_valid_reg;
    logic [7:0] out_rdata_reg, out_rdata_next;
    logic [2:0] out_lines_reg, out_lines_next;

    logic out_free;
    logic proceed;

    pit3_cmd_t cmd   [NUM_SLOTS];
    pit3_rsp_t rsp   [NUM_SLOTS];

    // The result register frees up when empty or when its item is taken.
    assign out_free = !out_valid_reg || m_tready;
    assign proceed  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    genvar c;
    generate
        for (c = 0; c < NUM_SLOTS; c++) begin : g_chan
            if (c < CHANNELS) begin : g_on
                always_comb begin
                    cmd[c].tick = proceed && in_kind_reg == KIND_TICK;
                    cmd[c].rd   = proceed && in_kind_reg == KIND_READ
                                  && in_port_reg == 2'(c);
                    cmd[c].wr   = proceed && in_kind_reg == KIND_WRITE
                                  && in_port_reg == 2'(c);
                    cmd[c].ctrl = proceed && in_kind_reg == KIND_WRITE
                                  && in_port_reg == PORT_CTRL
                                  && in_data_reg[7:6] == 2'(c);
                    cmd[c].data = in_data_reg;
                end

                pit3_channel u_chan (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .cmd     (cmd[c]),
                    .rsp     (rsp[c])
                );
            end else begin : g_off
                always_comb begin
                    cmd[c]          = '0;
                    rsp[c].rdata    = 8'hff;
                    rsp[c].out_line = 1'b0;
                end
            end
        end
    endgenerate

    always_comb begin
        out_rdata_next = 8'hff;
        if (in_kind_reg == KIND_READ && in_port_reg != PORT_CTRL) begin
            out_rdata_next = rsp[in_port_reg].rdata;
        end
        out_lines_next = {rsp[2].out_line, rsp[1].out_line, rsp[0].out_line};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tdata[1:0];
            in_port_reg <= s_tdata[3:2];
            in_data_reg <= s_tdata[11:4];
        end
        if (proceed) begin
            out_rdata_reg <= out_rdata_next;
            out_lines_reg <= out_lines_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_lines_reg, out_rdata_reg};

endmodule

`default_nettype wire

// File: tb/sv/interval_timer_three_channel_unit_tb.sv
// Self-checking testbench for the three-channel interval timer top level.
// Depends on pit3_pkg and the interval_timer_three_channel_unit RTL only.
`timescale 1ns / 100ps

module interval_timer_three_channel_unit_tb;
    import pit3_pkg::*;

    // Codes that the package leaves out but the stimulus needs by name.
    localparam logic [1:0] KIND_NONE     = 2'd3;
    localparam logic [1:0] SEL_READBACK  = 2'd3;
    localparam logic [2:0] MODE_TERMINAL = 3'd0;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    // One result item, split into its fields.
    typedef struct {
        logic [7:0] read_data;
        logic       out_zero;
        logic       out_one;
        logic       out_two;
    } timer_result_t;

    // One row of stimulus; known_result marks rows whose result is typed in.
    typedef struct {
        logic [1:0]    kind;
        logic [1:0]    port;
        logic [7:0]    data;
        bit            known_result;
        timer_result_t result;
    } timer_stim_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    interval_timer_three_channel_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Timer state as the checker sees it, one entry per channel.
    logic [16:0] reload_q  [3];
    logic [15:0] phase_q   [3];
    logic [16:0] elapsed_q [3];
    logic [2:0]  mode_q    [3];
    logic [1:0]  access_q  [3];
    bit          read_hi_q [3];
    bit          write_hi_q[3];
    bit          latched_q [3];
    logic [16:0] latch_val [3];
    logic [15:0] hold_q    [3];

    timer_result_t pending_results[$];
    timer_stim_t   directed_rows[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  items_sent;
    int  results_seen;
    int  mismatch_count;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_off_req;

    // ---------------------------------------------------------------------
    // Timer prediction
    // ---------------------------------------------------------------------

    function automatic void clear_timer_state();
        for (int c = 0; c < 3; c++) begin
            reload_q[c]   = '0;
            phase_q[c]    = '0;
            elapsed_q[c]  = '0;
            mode_q[c]     = MODE_TERMINAL;
            access_q[c]   = ACC_LATCH;
            read_hi_q[c]  = 1'b0;
            write_hi_q[c] = 1'b0;
            latched_q[c]  = 1'b0;
            latch_val[c]  = '0;
            hold_q[c]     = '0;
        end
    endfunction

    // Current count of a channel; an unprogrammed channel reads zero.
    function automatic logic [16:0] live_count(int c);
        if (reload_q[c] == '0)
            return '0;
        if (mode_q[c] == MODE_RATE || mode_q[c] == MODE_SQUARE)
            return reload_q[c] - {1'b0, phase_q[c]};
        if (elapsed_q[c] >= reload_q[c])
            return '0;
        return reload_q[c] - elapsed_q[c];
    endfunction

    function automatic logic out_line(int c);
        logic [17:0] half;
        half = ({1'b0, reload_q[c]} + 18'd1) >> 1;
        if (reload_q[c] == '0)
            return 1'b0;
        if (mode_q[c] == MODE_SQUARE)
            return {2'b00, phase_q[c]} < half;
        if (mode_q[c] == MODE_RATE)
            return {1'b0, phase_q[c]} != reload_q[c] - 17'd1;
        return elapsed_q[c] >= reload_q[c];
    endfunction

    // Phase wraps at the reload value; elapsed saturates there.
    function automatic void tick_channel(int c);
        if (reload_q[c] != '0) begin
            if ({1'b0, phase_q[c]} + 17'd1 >= reload_q[c])
                phase_q[c] = '0;
            else
                phase_q[c] = phase_q[c] + 16'd1;
            if (elapsed_q[c] < reload_q[c])
                elapsed_q[c] = elapsed_q[c] + 17'd1;
        end
    endfunction

    // In word access the low byte comes first, and a held latch is only
    // released once the high byte has been read.
    function automatic logic [7:0] read_channel(int c);
        logic [16:0] cnt;
        logic [7:0]  byte_out;
        cnt = latched_q[c] ? latch_val[c] : live_count(c);
        if (access_q[c] == ACC_MSB) begin
            byte_out = cnt[15:8];
        end else if (access_q[c] == ACC_WORD) begin
            byte_out = read_hi_q[c] ? cnt[15:8] : cnt[7:0];
            read_hi_q[c] = ~read_hi_q[c];
            if (read_hi_q[c])
                return byte_out;
        end else begin
            byte_out = cnt[7:0];
        end
        latched_q[c] = 1'b0;
        return byte_out;
    endfunction

    function automatic void write_control(logic [7:0] word);
        int         c;
        logic [2:0] m;
        c = int'(word[7:6]);
        if (word[7:6] == SEL_READBACK)
            return;
        if (word[5:4] == ACC_LATCH) begin
            // A second latch command is ignored while one is still held.
            if (!latched_q[c]) begin
                latch_val[c] = live_count(c);
                latched_q[c] = 1'b1;
            end
            return;
        end
        m = word[3:1];
        if (m > MODE_LAST)
            m = m - MODE_FOLD;
        access_q[c]   = word[5:4];
        mode_q[c]     = m;
        write_hi_q[c] = 1'b0;
        read_hi_q[c]  = 1'b0;
        latched_q[c]  = 1'b0;
    endfunction

    function automatic void write_reload_byte(int c, logic [7:0] value);
        if (access_q[c] == ACC_WORD) begin
            if (!write_hi_q[c]) begin
                hold_q[c] = {8'h00, value};
                write_hi_q[c] = 1'b1;
                return;
            end
            hold_q[c] = hold_q[c] | {value, 8'h00};
            write_hi_q[c] = 1'b0;
        end else if (access_q[c] == ACC_MSB) begin
            hold_q[c] = {value, 8'h00};
        end else begin
            hold_q[c] = {8'h00, value};
        end
        reload_q[c]  = (hold_q[c] != '0) ? {1'b0, hold_q[c]} : FULL_COUNT;
        phase_q[c]   = '0;
        elapsed_q[c] = '0;
    endfunction

    function automatic timer_result_t predict_timer(logic [1:0] kind, logic [1:0] port,
                                                    logic [7:0] data);
        timer_result_t r;
        r.read_data = 8'hFF;
        case (kind)
            KIND_TICK: begin
                for (int c = 0; c < 3; c++)
                    tick_channel(c);
            end
            KIND_READ: begin
                if (port != PORT_CTRL)
                    r.read_data = read_channel(int'(port));
            end
            KIND_WRITE: begin
                if (port == PORT_CTRL)
                    write_control(data);
                else
                    write_reload_byte(int'(port), data);
            end
            default: begin
            end
        endcase
        r.out_zero = out_line(0);
        r.out_one  = out_line(1);
        r.out_two  = out_line(2);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [7:0] ctrl_word(logic [1:0] sel, logic [1:0] acc,
                                             logic [2:0] mode);
        return {sel, acc, mode, 1'b0};
    endfunction

    function automatic timer_stim_t stim(logic [1:0] kind, logic [1:0] port,
                                         logic [7:0] data);
        timer_stim_t s;
        s.kind = kind;
        s.port = port;
        s.data = data;
        s.known_result = 1'b0;
        s.result = '{8'h00, 1'b0, 1'b0, 1'b0};
        return s;
    endfunction

    // Row whose result is obvious at a glance: all OUT lines still low.
    function automatic timer_stim_t stim_known(logic [1:0] kind, logic [1:0] port,
                                               logic [7:0] data, logic [7:0] rd);
        timer_stim_t s;
        s = stim(kind, port, data);
        s.known_result = 1'b1;
        s.result = '{rd, 1'b0, 1'b0, 1'b0};
        return s;
    endfunction

    // Offers one item, starting at a falling edge and returning at the
    // falling edge after it was taken. The predictor runs at the accepting
    // edge, so expectations queue up in acceptance order.
    task automatic send_item(timer_stim_t s);
        timer_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, s.data, s.port, s.kind};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = predict_timer(s.kind, s.port, s.data);
        if (s.known_result)
            pending_results.push_back(s.result);
        else
            pending_results.push_back(predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stops offering and waits for every outstanding result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [15:0] random_reload();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return 16'($urandom_range(1, 24));
        if (pick < 9)
            return 16'($urandom_range(0, 65535));
        return 16'h0000;
    endfunction

    // Random traffic made mostly of well-formed sequences: programming a
    // channel, bursts of ticks, reads and latch-then-read, with some noise.
    task automatic run_random(int count);
        int          target;
        int          pick;
        int          n;
        logic [1:0]  ch;
        logic [1:0]  acc;
        logic [15:0] value;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            ch   = 2'($urandom_range(0, 2));
            if (pick < 20) begin
                acc   = 2'($urandom_range(1, 3));
                value = random_reload();
                send_item(stim(KIND_WRITE, PORT_CTRL,
                               ctrl_word(ch, acc, 3'($urandom_range(0, 7)))));
                if (acc == ACC_MSB) begin
                    // Keep most MSB-only periods short enough to expire.
                    value[15:8] = ($urandom_range(0, 3) == 0) ? value[15:8] : 8'd1;
                    send_item(stim(KIND_WRITE, ch, value[15:8]));
                end else begin
                    send_item(stim(KIND_WRITE, ch, value[7:0]));
                    if (acc == ACC_WORD)
                        send_item(stim(KIND_WRITE, ch, value[15:8]));
                end
            end else if (pick < 55) begin
                n = $urandom_range(1, 12);
                repeat (n) send_item(stim(KIND_TICK, 2'($urandom_range(0, 3)),
                                          8'($urandom_range(0, 255))));
            end else if (pick < 72) begin
                n = $urandom_range(1, 2);
                repeat (n) send_item(stim(KIND_READ, ch, 8'($urandom_range(0, 255))));
            end else if (pick < 84) begin
                send_item(stim(KIND_WRITE, PORT_CTRL,
                               ctrl_word(ch, ACC_LATCH, 3'($urandom_range(0, 7)))));
                n = $urandom_range(0, 2);
                repeat (n) send_item(stim(KIND_READ, ch, 8'($urandom_range(0, 255))));
            end else begin
                send_item(stim(2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255))));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("result %0d: %s mismatch, got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Every accepted result is compared field by field with the oldest
    // expectation; a result with nothing queued is a failure of its own.
    always @(posedge aclk) begin
        timer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, read_data", m_tdata[7:0], 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.read_data)
                    report_mismatch("read_data", m_tdata[7:0], want.read_data);
                if (m_tdata[8] !== want.out_zero)
                    report_mismatch("out_zero", m_tdata[8], want.out_zero);
                if (m_tdata[9] !== want.out_one)
                    report_mismatch("out_one", m_tdata[9], want.out_one);
                if (m_tdata[10] !== want.out_two)
                    report_mismatch("out_two", m_tdata[10], want.out_two);
            end
            results_seen++;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so
    // that both internal registers fill and s_tready has to drop.
    always @(negedge aclk) begin
        if (hold_off_req) begin
            hold_off_req <= 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // The run is declared hung after a long stretch with no handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("interval_timer_three_channel_unit_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        hold_off_req   = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        send_idle_pct  = 30;
        recv_idle_pct  = 51;
        clear_timer_state();

        // Rows with a typed result: reads and ticks straight after reset,
        // the ignored kind, and a zero reload byte, which means 65536 and
        // therefore reads back a zero low byte.
        directed_rows.push_back(stim_known(KIND_READ, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(stim_known(KIND_READ, PORT_CTRL, 8'h00, 8'hFF));
        directed_rows.push_back(stim_known(KIND_TICK, 2'd0, 8'h00, 8'hFF));
        directed_rows.push_back(stim_known(KIND_NONE, 2'd0, 8'hFF, 8'hFF));
        directed_rows.push_back(stim_known(KIND_WRITE, 2'd0, 8'h00, 8'hFF));
        directed_rows.push_back(stim_known(KIND_READ, 2'd0, 8'h00, 8'h00));
        // Rate generator of period 3 on channel 0, word access.
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(2'd0, ACC_WORD, MODE_RATE)));
        directed_rows.push_back(stim(KIND_WRITE, 2'd0, 8'h03));
        directed_rows.push_back(stim(KIND_WRITE, 2'd0, 8'h00));
        // Square wave with the largest explicit reload on channel 1.
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(2'd1, ACC_WORD, MODE_SQUARE)));
        directed_rows.push_back(stim(KIND_WRITE, 2'd1, 8'hFF));
        directed_rows.push_back(stim(KIND_WRITE, 2'd1, 8'hFF));
        // Mode 7 on channel 2 must fold down to the square wave.
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(2'd2, ACC_WORD, MODE_SQUARE + MODE_FOLD)));
        directed_rows.push_back(stim(KIND_WRITE, 2'd2, 8'h05));
        directed_rows.push_back(stim(KIND_WRITE, 2'd2, 8'h00));
        directed_rows.push_back(stim(KIND_TICK, 2'd1, 8'h00));
        directed_rows.push_back(stim(KIND_TICK, 2'd2, 8'h00));
        directed_rows.push_back(stim(KIND_TICK, PORT_CTRL, 8'h00));
        // Latch twice (the second is ignored), tick, then read both bytes.
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(2'd0, ACC_LATCH, MODE_TERMINAL)));
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(2'd0, ACC_LATCH, MODE_TERMINAL)));
        directed_rows.push_back(stim(KIND_TICK, 2'd0, 8'h00));
        directed_rows.push_back(stim(KIND_READ, 2'd0, 8'h00));
        directed_rows.push_back(stim(KIND_READ, 2'd0, 8'h00));
        // Read-back selector is ignored; then MSB-only access on channel 2.
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(SEL_READBACK, ACC_WORD, MODE_TERMINAL)));
        directed_rows.push_back(stim(KIND_WRITE, PORT_CTRL,
                                     ctrl_word(2'd2, ACC_MSB, MODE_LAST)));
        directed_rows.push_back(stim(KIND_WRITE, 2'd2, 8'h01));

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        wait_drained();

        // Phase one: the receiver holds off for a long stretch while the
        // sender keeps offering, so the block fills up and stalls its input.
        @(posedge aclk);
        hold_off_req <= 1'b1;
        @(negedge aclk);
        run_random(175);
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 30;
        run_random(175);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(175);
        wait_drained();

        // Leave room for any stray result to show up.
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("interval_timer_three_channel_unit_tb: PASS");
        else
            $display("interval_timer_three_channel_unit_tb: FAIL");
        $finish;
    end

endmodule
